// ===== sv/stok_pkg.sv =====
// Shared types, codes, keyword tables and character helpers for the tokenizer.
`timescale 1ns / 1ps
package stok_pkg;

  typedef enum logic [4:0] {
    ST_START, ST_IDENT, ST_VAR_D, ST_VAR_ID, ST_INT, ST_DOUBLE, ST_EXP_E, ST_EXP,
    ST_STRING, ST_ESC, ST_HEX1, ST_HEX2, ST_EQ, ST_EQ2, ST_NOT1, ST_NOT2,
    ST_LESS, ST_PHP1, ST_PHP2, ST_PHP3, ST_MORE, ST_DIV, ST_BCMT, ST_LCMT,
    ST_BCMT_STAR
  } st_e_t;

  localparam logic [5:0] TK_ERROR  = 6'd0;
  localparam logic [5:0] TK_END    = 6'd1;
  localparam logic [5:0] TK_IDENT  = 6'd2;
  localparam logic [5:0] TK_VAR    = 6'd3;
  localparam logic [5:0] TK_INT    = 6'd4;
  localparam logic [5:0] TK_DOUBLE = 6'd5;
  localparam logic [5:0] TK_STRING = 6'd6;
  localparam logic [5:0] TK_COMMA  = 6'd14;
  localparam logic [5:0] TK_SEMI   = 6'd15;
  localparam logic [5:0] TK_LPAR   = 6'd16;
  localparam logic [5:0] TK_RPAR   = 6'd17;
  localparam logic [5:0] TK_LCUR   = 6'd18;
  localparam logic [5:0] TK_RCUR   = 6'd19;
  localparam logic [5:0] TK_ASSIGN = 6'd20;
  localparam logic [5:0] TK_PLUS   = 6'd21;
  localparam logic [5:0] TK_MINUS  = 6'd22;
  localparam logic [5:0] TK_MUL    = 6'd23;
  localparam logic [5:0] TK_CONCAT = 6'd24;
  localparam logic [5:0] TK_DIV    = 6'd25;
  localparam logic [5:0] TK_IS     = 6'd26;
  localparam logic [5:0] TK_ISNOT  = 6'd27;
  localparam logic [5:0] TK_LT     = 6'd28;
  localparam logic [5:0] TK_LE     = 6'd29;
  localparam logic [5:0] TK_GT     = 6'd30;
  localparam logic [5:0] TK_GE     = 6'd31;
  localparam logic [5:0] TK_PHP    = 6'd32;

  localparam logic [7:0] KW_ALL_LIVE = 8'hFF;
  localparam logic [3:0] LEN_MAX     = 4'd15;
  localparam logic [7:0] CTRL_MAX    = 8'd31;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_TAB      = 8'd9;

  // else, function, if, return, while, false, null, true
  localparam logic [7:0] WORD_TEXT [8][8] = '{
    '{"e", "l", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"f", "u", "n", "c", "t", "i", "o", "n"},
    '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"r", "e", "t", "u", "r", "n", 8'd0, 8'd0},
    '{"w", "h", "i", "l", "e", 8'd0, 8'd0, 8'd0},
    '{"f", "a", "l", "s", "e", 8'd0, 8'd0, 8'd0},
    '{"n", "u", "l", "l", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"t", "r", "u", "e", 8'd0, 8'd0, 8'd0, 8'd0}
  };
  localparam logic [3:0] WORD_LEN  [8] = '{4'd4, 4'd8, 4'd2, 4'd6, 4'd5, 4'd5, 4'd4, 4'd4};
  localparam logic [5:0] WORD_CODE [8] = '{6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd7, 6'd8, 6'd7};

  typedef struct packed {
    logic       is_token;
    logic [7:0] attr_byte;
    logic [5:0] token_code;
  } res_t;

  typedef struct packed {
    logic       rescan;
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    st_e_t      st;
    logic [3:0] hex;
    logic [7:0] kc;
    logic [3:0] len;
  } pass_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // bit 4 set = not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (is_digit(c)) d = c - 8'd48;
    else if (c >= "a" && c <= "f") d = c - 8'd87;
    else if (c >= "A" && c <= "F") d = c - 8'd55;
    else d = 8'd16;
    return d[4:0];
  endfunction

endpackage

// ===== sv/stok_if.sv =====
// Word channels of the tokenizer: source input and result output.
`timescale 1ns / 1ps
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_of_input;
  modport source (output valid, output src_byte, output end_of_input, input ready);
  modport sink (input valid, input src_byte, input end_of_input, output ready);
endinterface

interface stok_out_if;
  logic       valid;
  logic       ready;
  logic       is_token;
  logic [7:0] attr_byte;
  logic [5:0] token_code;
  logic       last_of_run;
  modport source (output valid, output is_token, output attr_byte, output token_code,
                  output last_of_run, input ready);
  modport sink (input valid, input is_token, input attr_byte, input token_code,
                input last_of_run, output ready);
endinterface

// ===== sv/script_language_tokenizer_core.sv =====
// Top level of the character-at-a-time script tokenizer.
`timescale 1ns / 1ps
// Takes one source byte (or an end-of-input mark) per input word and returns
// zero, one or two result words for it: appended attribute bytes and finished
// token codes, the last one flagged by last_of_run. A byte is latched in an
// input register; once the result register is free, the whole scanner step,
// including a rescan of a lookahead byte from the start state, runs in one
// combinational pass and loads a two-slot result register while the scanner
// state updates. The result register sends one word per cycle while the
// receiver is ready; the result register draining is the only limit.
module script_language_tokenizer_core (
  input  logic clk,
  input  logic rst_n,
  stok_in_if.sink    in_ch,
  stok_out_if.source out_ch
);

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eof_r;

  // scanner state
  stok_pkg::st_e_t st_r;
  logic [3:0]      hex_r;
  logic [7:0]      kc_r;
  logic [3:0]      len_r;

  // result register
  stok_pkg::res_t slot0_r, slot1_r;
  logic [1:0]     rem_r;
  logic           head_r;

  logic          drain_last, free, load;
  stok_pkg::pass_t p1, p2, p2_in;
  logic [1:0]    cnt_nxt;
  stok_pkg::res_t s0_nxt, s1_nxt;

  function automatic stok_pkg::pass_t add1(input stok_pkg::pass_t p, input logic [7:0] b);
    stok_pkg::pass_t q;
    q = p;
    q.cnt = 2'd1;
    q.r0 = '{is_token: 1'b0, attr_byte: b, token_code: stok_pkg::TK_ERROR};
    return q;
  endfunction

  function automatic stok_pkg::pass_t fin(input stok_pkg::pass_t p, input logic [5:0] code);
    stok_pkg::pass_t q;
    q = p;
    q.cnt = 2'd1;
    q.r0 = '{is_token: 1'b1, attr_byte: 8'd0, token_code: code};
    q.st = stok_pkg::ST_START;
    q.kc = stok_pkg::KW_ALL_LIVE;
    q.len = 4'd0;
    return q;
  endfunction

  function automatic stok_pkg::pass_t track(input stok_pkg::pass_t p, input logic [7:0] c);
    stok_pkg::pass_t q;
    q = p;
    for (int i = 0; i < 8; i++) begin
      if (p.len >= stok_pkg::WORD_LEN[i] || stok_pkg::WORD_TEXT[i][p.len[2:0]] != c)
        q.kc[i] = 1'b0;
    end
    if (p.len < stok_pkg::LEN_MAX) q.len = p.len + 4'd1;
    return q;
  endfunction

  function automatic logic [5:0] word_result(input stok_pkg::pass_t p);
    logic [5:0] code;
    code = stok_pkg::TK_IDENT;
    for (int i = 7; i >= 0; i--) begin
      if (p.kc[i] && stok_pkg::WORD_LEN[i] == p.len) code = stok_pkg::WORD_CODE[i];
    end
    return code;
  endfunction

  function automatic stok_pkg::pass_t start_scan(input stok_pkg::pass_t p0,
                                                 input logic [7:0] c, input logic eof);
    stok_pkg::pass_t p;
    p = p0;
    p.st = stok_pkg::ST_START;
    if (eof) begin
      p = fin(p, stok_pkg::TK_END);
    end else if (stok_pkg::is_space(c)) begin
      p = p;
    end else if (stok_pkg::is_alpha(c) || c == "_") begin
      p = add1(p, c);
      p.kc = stok_pkg::KW_ALL_LIVE;
      p.len = 4'd0;
      p = track(p, c);
      p.st = stok_pkg::ST_IDENT;
    end else if (c == "$") begin
      p = add1(p, c);
      p.st = stok_pkg::ST_VAR_D;
    end else if (stok_pkg::is_digit(c)) begin
      p = add1(p, c);
      p.st = stok_pkg::ST_INT;
    end else begin
      case (c)
        ",": p = fin(p, stok_pkg::TK_COMMA);
        ";": p = fin(p, stok_pkg::TK_SEMI);
        "(": p = fin(p, stok_pkg::TK_LPAR);
        ")": p = fin(p, stok_pkg::TK_RPAR);
        "{": p = fin(p, stok_pkg::TK_LCUR);
        "}": p = fin(p, stok_pkg::TK_RCUR);
        "+": p = fin(p, stok_pkg::TK_PLUS);
        "-": p = fin(p, stok_pkg::TK_MINUS);
        "*": p = fin(p, stok_pkg::TK_MUL);
        ".": p = fin(p, stok_pkg::TK_CONCAT);
        "\"": p.st = stok_pkg::ST_STRING;
        "=": p.st = stok_pkg::ST_EQ;
        "!": p.st = stok_pkg::ST_NOT1;
        "<": p.st = stok_pkg::ST_LESS;
        ">": p.st = stok_pkg::ST_MORE;
        "/": p.st = stok_pkg::ST_DIV;
        default: p = fin(p, stok_pkg::TK_ERROR);
      endcase
    end
    return p;
  endfunction

  function automatic stok_pkg::pass_t scan(input stok_pkg::pass_t p0,
                                           input logic [7:0] c, input logic eof);
    stok_pkg::pass_t p;
    logic wrd, dig;
    logic [4:0] hv;
    p = p0;
    p.cnt = 2'd0;
    p.rescan = 1'b0;
    p.r0 = '0;
    p.r1 = '0;
    wrd = !eof && (stok_pkg::is_alpha(c) || stok_pkg::is_digit(c) || c == "_");
    dig = !eof && stok_pkg::is_digit(c);
    hv = eof ? 5'd16 : stok_pkg::hex_value(c);
    case (p0.st)
      stok_pkg::ST_IDENT: begin
        if (wrd) begin
          p = add1(p, c);
          p = track(p, c);
        end else begin
          p = fin(p, word_result(p0));
          p.rescan = 1'b1;
        end
      end
      stok_pkg::ST_VAR_D: begin
        if (!eof && (stok_pkg::is_alpha(c) || c == "_")) begin
          p = add1(p, c);
          p.st = stok_pkg::ST_VAR_ID;
        end else p = fin(p, stok_pkg::TK_ERROR);
      end
      stok_pkg::ST_VAR_ID: begin
        if (wrd) p = add1(p, c);
        else begin
          p = fin(p, stok_pkg::TK_VAR);
          p.rescan = 1'b1;
        end
      end
      stok_pkg::ST_INT, stok_pkg::ST_DOUBLE: begin
        if (dig) p = add1(p, c);
        else if (!eof && (c == "e" || c == "E")) begin
          p = add1(p, c);
          p.st = stok_pkg::ST_EXP_E;
        end else if (!eof && c == "." && p0.st == stok_pkg::ST_INT) begin
          p = add1(p, c);
          p.st = stok_pkg::ST_DOUBLE;
        end else begin
          p = fin(p, (p0.st == stok_pkg::ST_INT) ? stok_pkg::TK_INT : stok_pkg::TK_DOUBLE);
          p.rescan = 1'b1;
        end
      end
      stok_pkg::ST_EXP_E: begin
        if (dig || (!eof && (c == "+" || c == "-"))) begin
          p = add1(p, c);
          p.st = stok_pkg::ST_EXP;
        end else p = fin(p, stok_pkg::TK_ERROR);
      end
      stok_pkg::ST_EXP: begin
        if (dig) p = add1(p, c);
        else begin
          p = fin(p, stok_pkg::TK_DOUBLE);
          p.rescan = 1'b1;
        end
      end
      stok_pkg::ST_STRING: begin
        p.hex = 4'd0;
        if (eof) p = fin(p, stok_pkg::TK_ERROR);
        else if (c == "\"") p = fin(p, stok_pkg::TK_STRING);
        else if (c == "\\") p.st = stok_pkg::ST_ESC;
        else if (c > stok_pkg::CTRL_MAX && c != "$") p = add1(p, c);
        else p = fin(p, stok_pkg::TK_ERROR);
      end
      stok_pkg::ST_ESC: begin
        if (eof || c <= stok_pkg::CTRL_MAX) p = fin(p, stok_pkg::TK_ERROR);
        else begin
          p.st = stok_pkg::ST_STRING;
          if (c == "x") p.st = stok_pkg::ST_HEX1;
          else if (c == "n") p = add1(p, stok_pkg::CH_LF);
          else if (c == "t") p = add1(p, stok_pkg::CH_TAB);
          else if (c == "$" || c == "\\" || c == "\"") p = add1(p, c);
          else begin
            // unknown escape keeps the backslash
            p = add1(p, "\\");
            p.cnt = 2'd2;
            p.r1 = '{is_token: 1'b0, attr_byte: c, token_code: stok_pkg::TK_ERROR};
          end
        end
      end
      stok_pkg::ST_HEX1, stok_pkg::ST_HEX2: begin
        if (hv[4]) p = fin(p, stok_pkg::TK_ERROR);
        else if (p0.st == stok_pkg::ST_HEX1) begin
          p.hex = hv[3:0];
          p.st = stok_pkg::ST_HEX2;
        end else begin
          p = add1(p, {p0.hex, hv[3:0]});
          p.st = stok_pkg::ST_STRING;
        end
      end
      stok_pkg::ST_EQ: begin
        if (!eof && c == "=") p.st = stok_pkg::ST_EQ2;
        else begin
          p = fin(p, stok_pkg::TK_ASSIGN);
          p.rescan = 1'b1;
        end
      end
      stok_pkg::ST_EQ2:
        p = fin(p, (!eof && c == "=") ? stok_pkg::TK_IS : stok_pkg::TK_ERROR);
      stok_pkg::ST_NOT1: begin
        if (!eof && c == "=") p.st = stok_pkg::ST_NOT2;
        else p = fin(p, stok_pkg::TK_ERROR);
      end
      stok_pkg::ST_NOT2:
        p = fin(p, (!eof && c == "=") ? stok_pkg::TK_ISNOT : stok_pkg::TK_ERROR);
      stok_pkg::ST_LESS: begin
        if (!eof && c == "?") p.st = stok_pkg::ST_PHP1;
        else if (!eof && c == "=") p = fin(p, stok_pkg::TK_LE);
        else begin
          p = fin(p, stok_pkg::TK_LT);
          p.rescan = 1'b1;
        end
      end
      stok_pkg::ST_PHP1: begin
        if (!eof && c == "p") p.st = stok_pkg::ST_PHP2;
        else p = fin(p, stok_pkg::TK_ERROR);
      end
      stok_pkg::ST_PHP2: begin
        if (!eof && c == "h") p.st = stok_pkg::ST_PHP3;
        else p = fin(p, stok_pkg::TK_ERROR);
      end
      stok_pkg::ST_PHP3:
        p = fin(p, (!eof && c == "p") ? stok_pkg::TK_PHP : stok_pkg::TK_ERROR);
      stok_pkg::ST_MORE: begin
        if (!eof && c == "=") p = fin(p, stok_pkg::TK_GE);
        else begin
          p = fin(p, stok_pkg::TK_GT);
          p.rescan = 1'b1;
        end
      end
      stok_pkg::ST_DIV: begin
        if (!eof && c == "/") p.st = stok_pkg::ST_LCMT;
        else if (!eof && c == "*") p.st = stok_pkg::ST_BCMT;
        else begin
          p = fin(p, stok_pkg::TK_DIV);
          p.rescan = 1'b1;
        end
      end
      stok_pkg::ST_BCMT: begin
        if (eof) p = fin(p, stok_pkg::TK_END);
        else if (c == "*") p.st = stok_pkg::ST_BCMT_STAR;
      end
      stok_pkg::ST_BCMT_STAR: begin
        if (eof) p = fin(p, stok_pkg::TK_END);
        else p.st = (c == "/") ? stok_pkg::ST_START : stok_pkg::ST_BCMT;
      end
      stok_pkg::ST_LCMT: begin
        if (eof) p = fin(p, stok_pkg::TK_END);
        else if (c == stok_pkg::CH_LF) p.st = stok_pkg::ST_START;
      end
      default: p = start_scan(p, c, eof);
    endcase
    return p;
  endfunction

  // result register handshake
  assign drain_last = out_ch.valid && out_ch.ready && (rem_r == 2'd1);
  assign free       = (rem_r == 2'd0) || drain_last;
  assign load       = in_vld_r && free;
  assign in_ch.ready = !in_vld_r || load;

  // scanner step: first pass, then a rescan from start when a token ended by lookahead
  always_comb begin
    p1 = '0;
    p1.st  = st_r;
    p1.hex = hex_r;
    p1.kc  = kc_r;
    p1.len = len_r;
    p1 = scan(p1, in_byte_r, in_eof_r);
    p2_in = p1;
    p2_in.cnt = 2'd0;
    p2_in.r0 = '0;
    p2_in.r1 = '0;
    p2_in.rescan = 1'b0;
    p2 = start_scan(p2_in, in_byte_r, in_eof_r);
    if (!p1.rescan) p2 = p1;
    s0_nxt = p1.r0;
    s1_nxt = p1.r1;
    cnt_nxt = p1.cnt;
    if (p1.rescan) begin
      s1_nxt = p2.r0;
      cnt_nxt = p1.cnt + p2.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= stok_pkg::ST_START;
      hex_r    <= 4'd0;
      kc_r     <= stok_pkg::KW_ALL_LIVE;
      len_r    <= 4'd0;
      rem_r    <= 2'd0;
      head_r   <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r  <= 1'b1;
        in_byte_r <= in_ch.src_byte;
        in_eof_r  <= in_ch.end_of_input;
      end else if (load) begin
        in_vld_r <= 1'b0;
      end
      if (load) begin
        st_r    <= p2.st;
        hex_r   <= p2.hex;
        kc_r    <= p2.kc;
        len_r   <= p2.len;
        slot0_r <= s0_nxt;
        slot1_r <= s1_nxt;
        rem_r   <= cnt_nxt;
        head_r  <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        rem_r  <= rem_r - 2'd1;
        head_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid       = (rem_r != 2'd0);
  assign out_ch.is_token    = head_r ? slot1_r.is_token : slot0_r.is_token;
  assign out_ch.attr_byte   = head_r ? slot1_r.attr_byte : slot0_r.attr_byte;
  assign out_ch.token_code  = head_r ? slot1_r.token_code : slot0_r.token_code;
  assign out_ch.last_of_run = (rem_r == 2'd1);

  // a word that is not the last of its byte is followed by another
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> out_ch.valid)
    else $error("second word of a pair went missing");

  // a pending byte with an empty result register is always consumed
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && rem_r == 2'd0) |-> load)
    else $error("pending byte not scanned");

  // the second slot is only read when two words were loaded
  a_head_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && head_r) |-> (rem_r == 2'd1))
    else $error("result slot pointer out of step");

  // a byte waiting in the input register blocks a new one unless it moves on
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !free) |-> !in_ch.ready)
    else $error("input register overwritten");

endmodule

// ===== tb/sv/tb_script_language_tokenizer_core.sv =====
// Self-checking testbench for the script tokenizer core.
`timescale 1ns / 1ps
module tb_script_language_tokenizer_core;

  logic clk;
  logic rst_n;

  stok_in_if  src_ch ();
  stok_out_if res_ch ();

  script_language_tokenizer_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(src_ch.sink), .out_ch(res_ch.source)
  );

  typedef struct packed {
    logic       is_token;
    logic [7:0] attr_byte;
    logic [5:0] token_code;
    logic       last_of_run;
  } tok_word_t;

  int n_errors = 0;

  // one printed line per mismatch, counted
  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Scanner prediction plus the queue of words it is waiting for.
  class token_scoreboard;
    stok_pkg::st_e_t st;
    logic [3:0]      hex_hi;
    logic [7:0]      kw_live;
    logic [3:0]      id_len;
    tok_word_t       pending[$];
    tok_word_t       step_words[$];

    function new();
      st = stok_pkg::ST_START; hex_hi = 4'd0; kw_live = stok_pkg::KW_ALL_LIVE;
      id_len = 4'd0;
    endfunction

    function void emit(input logic tok, input logic [7:0] b, input logic [5:0] code);
      tok_word_t w;
      if (step_words.size() >= 2) return;
      w.is_token = tok; w.attr_byte = tok ? 8'd0 : b;
      w.token_code = tok ? code : 6'd0; w.last_of_run = 1'b0;
      step_words.push_back(w);
    endfunction

    function void append(input logic [7:0] b);
      emit(1'b0, b, 6'd0);
    endfunction

    function void close_token(input logic [5:0] code);
      emit(1'b1, 8'd0, code);
      st = stok_pkg::ST_START; kw_live = stok_pkg::KW_ALL_LIVE; id_len = 4'd0;
    endfunction

    // narrow the live keyword set by one more identifier byte
    function void track_word(input logic [7:0] c);
      for (int i = 0; i < 8; i++)
        if (id_len >= stok_pkg::WORD_LEN[i] || stok_pkg::WORD_TEXT[i][id_len[2:0]] != c)
          kw_live[i] = 1'b0;
      if (id_len < stok_pkg::LEN_MAX) id_len++;
    endfunction

    function logic [5:0] word_code();
      for (int i = 0; i < 8; i++)
        if (kw_live[i] && stok_pkg::WORD_LEN[i] == id_len) return stok_pkg::WORD_CODE[i];
      return stok_pkg::TK_IDENT;
    endfunction

    function automatic logic alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction
    function automatic int hexval(input logic [7:0] c);
      if (digit(c)) return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    // one automaton pass; 1 means rescan the byte from start
    function logic scan_pass(input logic [7:0] c, input logic eof);
      logic wordc, dig;
      int hv;
      wordc = !eof && (alpha(c) || digit(c) || c == "_");
      dig = !eof && digit(c);
      case (st)
        stok_pkg::ST_IDENT: begin
          if (wordc) begin append(c); track_word(c); return 0; end
          close_token(word_code()); return 1;
        end
        stok_pkg::ST_VAR_D: begin
          if (!eof && (alpha(c) || c == "_")) begin
            append(c); st = stok_pkg::ST_VAR_ID;
          end else close_token(stok_pkg::TK_ERROR);
          return 0;
        end
        stok_pkg::ST_VAR_ID: begin
          if (wordc) begin append(c); return 0; end
          close_token(stok_pkg::TK_VAR); return 1;
        end
        stok_pkg::ST_INT, stok_pkg::ST_DOUBLE: begin
          if (dig) begin append(c); return 0; end
          if (!eof && (c == "e" || c == "E")) begin
            append(c); st = stok_pkg::ST_EXP_E; return 0;
          end
          if (!eof && c == "." && st == stok_pkg::ST_INT) begin
            append(c); st = stok_pkg::ST_DOUBLE; return 0;
          end
          close_token(st == stok_pkg::ST_INT ? stok_pkg::TK_INT : stok_pkg::TK_DOUBLE);
          return 1;
        end
        stok_pkg::ST_EXP_E: begin
          if (dig || (!eof && (c == "+" || c == "-"))) begin
            append(c); st = stok_pkg::ST_EXP;
          end else close_token(stok_pkg::TK_ERROR);
          return 0;
        end
        stok_pkg::ST_EXP: begin
          if (dig) begin append(c); return 0; end
          close_token(stok_pkg::TK_DOUBLE); return 1;
        end
        stok_pkg::ST_STRING: begin
          hex_hi = 4'd0;
          if (eof) close_token(stok_pkg::TK_ERROR);
          else if (c == "\"") close_token(stok_pkg::TK_STRING);
          else if (c == "\\") st = stok_pkg::ST_ESC;
          else if (c > stok_pkg::CTRL_MAX && c != "$") append(c);
          else close_token(stok_pkg::TK_ERROR);
          return 0;
        end
        stok_pkg::ST_ESC: begin
          if (eof || c <= stok_pkg::CTRL_MAX) begin
            close_token(stok_pkg::TK_ERROR); return 0;
          end
          st = stok_pkg::ST_STRING;
          if (c == "x") st = stok_pkg::ST_HEX1;
          else if (c == "n") append(stok_pkg::CH_LF);
          else if (c == "t") append(stok_pkg::CH_TAB);
          else if (c == "$" || c == "\\" || c == "\"") append(c);
          else begin append("\\"); append(c); end
          return 0;
        end
        stok_pkg::ST_HEX1, stok_pkg::ST_HEX2: begin
          hv = eof ? -1 : hexval(c);
          if (hv < 0) begin close_token(stok_pkg::TK_ERROR); return 0; end
          if (st == stok_pkg::ST_HEX1) begin hex_hi = hv[3:0]; st = stok_pkg::ST_HEX2; end
          else begin append({hex_hi, hv[3:0]}); st = stok_pkg::ST_STRING; end
          return 0;
        end
        stok_pkg::ST_EQ: begin
          if (!eof && c == "=") begin st = stok_pkg::ST_EQ2; return 0; end
          close_token(stok_pkg::TK_ASSIGN); return 1;
        end
        stok_pkg::ST_EQ2: begin
          close_token((!eof && c == "=") ? stok_pkg::TK_IS : stok_pkg::TK_ERROR);
          return 0;
        end
        stok_pkg::ST_NOT1: begin
          if (!eof && c == "=") st = stok_pkg::ST_NOT2;
          else close_token(stok_pkg::TK_ERROR);
          return 0;
        end
        stok_pkg::ST_NOT2: begin
          close_token((!eof && c == "=") ? stok_pkg::TK_ISNOT : stok_pkg::TK_ERROR);
          return 0;
        end
        stok_pkg::ST_LESS: begin
          if (!eof && c == "?") begin st = stok_pkg::ST_PHP1; return 0; end
          if (!eof && c == "=") begin close_token(stok_pkg::TK_LE); return 0; end
          close_token(stok_pkg::TK_LT); return 1;
        end
        stok_pkg::ST_PHP1: begin
          if (!eof && c == "p") st = stok_pkg::ST_PHP2;
          else close_token(stok_pkg::TK_ERROR);
          return 0;
        end
        stok_pkg::ST_PHP2: begin
          if (!eof && c == "h") st = stok_pkg::ST_PHP3;
          else close_token(stok_pkg::TK_ERROR);
          return 0;
        end
        stok_pkg::ST_PHP3: begin
          close_token((!eof && c == "p") ? stok_pkg::TK_PHP : stok_pkg::TK_ERROR);
          return 0;
        end
        stok_pkg::ST_MORE: begin
          if (!eof && c == "=") begin close_token(stok_pkg::TK_GE); return 0; end
          close_token(stok_pkg::TK_GT); return 1;
        end
        stok_pkg::ST_DIV: begin
          if (!eof && c == "/") begin st = stok_pkg::ST_LCMT; return 0; end
          if (!eof && c == "*") begin st = stok_pkg::ST_BCMT; return 0; end
          close_token(stok_pkg::TK_DIV); return 1;
        end
        stok_pkg::ST_BCMT: begin
          if (eof) close_token(stok_pkg::TK_END);
          else if (c == "*") st = stok_pkg::ST_BCMT_STAR;
          return 0;
        end
        stok_pkg::ST_BCMT_STAR: begin
          if (eof) close_token(stok_pkg::TK_END);
          else st = (c == "/") ? stok_pkg::ST_START : stok_pkg::ST_BCMT;
          return 0;
        end
        stok_pkg::ST_LCMT: begin
          if (eof) close_token(stok_pkg::TK_END);
          else if (c == stok_pkg::CH_LF) st = stok_pkg::ST_START;
          return 0;
        end
        default: ;
      endcase
      st = stok_pkg::ST_START;
      if (eof) begin close_token(stok_pkg::TK_END); return 0; end
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return 0;
      if (alpha(c) || c == "_") begin
        append(c); kw_live = stok_pkg::KW_ALL_LIVE; id_len = 4'd0; track_word(c);
        st = stok_pkg::ST_IDENT; return 0;
      end
      if (c == "$") begin append(c); st = stok_pkg::ST_VAR_D; return 0; end
      if (digit(c)) begin append(c); st = stok_pkg::ST_INT; return 0; end
      case (c)
        ",": close_token(stok_pkg::TK_COMMA);
        ";": close_token(stok_pkg::TK_SEMI);
        "(": close_token(stok_pkg::TK_LPAR);
        ")": close_token(stok_pkg::TK_RPAR);
        "{": close_token(stok_pkg::TK_LCUR);
        "}": close_token(stok_pkg::TK_RCUR);
        "+": close_token(stok_pkg::TK_PLUS);
        "-": close_token(stok_pkg::TK_MINUS);
        "*": close_token(stok_pkg::TK_MUL);
        ".": close_token(stok_pkg::TK_CONCAT);
        "\"": st = stok_pkg::ST_STRING;
        "=": st = stok_pkg::ST_EQ;
        "!": st = stok_pkg::ST_NOT1;
        "<": st = stok_pkg::ST_LESS;
        ">": st = stok_pkg::ST_MORE;
        "/": st = stok_pkg::ST_DIV;
        default: close_token(stok_pkg::TK_ERROR);
      endcase
      return 0;
    endfunction

    // accepted source word: predict its result words
    function void note_byte(input logic [7:0] c, input logic eof);
      step_words.delete();
      if (scan_pass(c, eof)) void'(scan_pass(c, eof));
      if (step_words.size() > 0) step_words[step_words.size()-1].last_of_run = 1'b1;
      foreach (step_words[i]) pending.push_back(step_words[i]);
    endfunction

    function string check_word(input tok_word_t got);
      tok_word_t exp_w;
      if (pending.size() == 0)
        return $sformatf("unexpected word tok=%0b byte=%02h code=%0d",
                         got.is_token, got.attr_byte, got.token_code);
      exp_w = pending.pop_front();
      if (got.is_token != exp_w.is_token || got.attr_byte != exp_w.attr_byte ||
          got.token_code != exp_w.token_code || got.last_of_run != exp_w.last_of_run)
        return $sformatf("got tok=%0b byte=%02h code=%0d last=%0b, want %0b %02h %0d %0b",
                         got.is_token, got.attr_byte, got.token_code, got.last_of_run,
                         exp_w.is_token, exp_w.attr_byte, exp_w.token_code,
                         exp_w.last_of_run);
      return "";
    endfunction
  endclass

  token_scoreboard sb = new();

  // source bytes waiting to go out, with their end marks
  logic [8:0] src_q[$];
  bit         hold_rx = 0;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // watchdog: slow correct run is far below this
  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  // monitor: both channels sampled at the edge
  always @(posedge clk) begin
    string msg;
    tok_word_t w;
    if (rst_n) begin
      if (src_ch.valid && src_ch.ready)
        sb.note_byte(src_ch.src_byte, src_ch.end_of_input);
      if (res_ch.valid && res_ch.ready) begin
        w = '{res_ch.is_token, res_ch.attr_byte, res_ch.token_code, res_ch.last_of_run};
        msg = sb.check_word(w);
        if (msg != "") report(msg);
      end
    end
  end

  // sender: random gap before each word, word held until accepted
  task automatic send_all();
    int gap;
    logic [8:0] it;
    while (src_q.size() > 0) begin
      it = src_q.pop_front();
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 1)) gap = 0;
      if (gap > 0) begin
        src_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      src_ch.valid <= 1'b1;
      src_ch.src_byte <= it[7:0];
      src_ch.end_of_input <= it[8];
      @(posedge clk);
      while (!src_ch.ready) @(posedge clk);
    end
    src_ch.valid <= 1'b0;
  endtask

  // receiver: random stall per word, plus one long hold-off
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_rx) begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
      end else begin
        stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        res_ch.ready <= 1'b1;
        @(posedge clk);
        while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
      end
    end
  end

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back({1'b0, s[i]});
  endtask

  task automatic queue_eof();
    src_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  // a random fragment of source: mostly well-formed, at times a stray byte or an end mark
  task automatic queue_fragment();
    string kw[8] = '{"else", "function", "if", "return", "while", "false", "null", "true"};
    string ops[20] = '{",", ";", "(", ")", "{", "}", "=", "+", "-", "*", ".", "/",
                       "===", "!==", "<", "<=", ">", ">=", "<?php", " "};
    string s;
    int n;
    case ($urandom_range(0, 9))
      0: queue_text({kw[$urandom_range(0, 7)], " "});
      1: begin
        s = "";
        n = $urandom_range(1, 18);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 2) == 0 ?
             $urandom_range("0", "9") : $urandom_range("a", "z")))};
        queue_text({"$", s, "+_", s, " "});
      end
      2: begin
        queue_text($sformatf("%0d", $urandom_range(0, 99999)));
        if ($urandom_range(0, 1)) queue_text($sformatf(".%0d", $urandom_range(0, 999)));
        if ($urandom_range(0, 1)) queue_text($urandom_range(0, 1) ? "e-7" : "E12");
        queue_text(";");
      end
      3: begin
        src_q.push_back({1'b0, 8'h22});
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 4))
            0: queue_text($sformatf("\\x%02h", 8'($urandom)));
            1: queue_text($urandom_range(0, 1) ? "\\n\\t" : "\\$\\\\\\\"\\q");
            2: src_q.push_back({1'b0, 8'($urandom_range(128, 255))});
            default: src_q.push_back({1'b0, 8'($urandom_range(32, 126))});
          endcase
          if (src_q[$][7:0] == "$" || src_q[$][7:0] == "\\" || src_q[$][7:0] == "\"")
            src_q[$][7:0] = "a";
        end
        src_q.push_back({1'b0, 8'h22});
      end
      4, 5: queue_text(ops[$urandom_range(0, 19)]);
      6: queue_text($urandom_range(0, 1) ? "/* x ** / */" : "// note\n");
      7: src_q.push_back({1'b0, 8'($urandom)});
      8: begin
        if ($urandom_range(0, 3) == 0) queue_eof();
        else src_q.push_back({1'b0, 8'($urandom_range(0, 127))});
      end
      default: queue_text({"fun", $urandom_range(0, 1) ? "ction(" : "x("});
    endcase
  endtask

  initial begin
    src_ch.valid = 1'b0;
    src_ch.src_byte = 8'd0;
    src_ch.end_of_input = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: keywords, operators, escapes, errors, end inside tokens
    queue_text("<?php if($a1===12.5e+3){return \"x\\x4Fz\\q\\n\";}");
    queue_eof();
    queue_text("\"\\x4g"); src_q.push_back({1'b0, 8'h00}); src_q.push_back({1'b0, 8'hFF});
    queue_text("12.");
    queue_eof();
    queue_text("!=<");
    queue_eof();

    // random fragments after the directed part
    while (src_q.size() < 1100) queue_fragment();
    queue_eof();

    // run the long receiver hold-off alongside the sender
    fork
      begin
        repeat (20) @(posedge clk);
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
      send_all();
    join

    // let the monitor note the last word before waiting on the results
    repeat (2) @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
